// ----- hdl/ezr_pkg.sv -----
// Package for the ZXY Euler-to-rotation-matrix block: widths, payload types, CORDIC tables, helpers.
`timescale 1ns / 1ps

package ezr_pkg;

  // Field and number formats.
  localparam int FIELD_BITS   = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = 14;
  localparam int OUT_BITS     = FRAC_BITS + 2;

  // CORDIC datapath: angles in a 32-bit turn, vector in Q.30.
  localparam int TURN_BITS    = 32;
  localparam int CORDIC_STEPS = 25;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_SHIFT = CORDIC_FRAC - FRAC_BITS;
  localparam int CORDIC_RND_W = CORDIC_W - CORDIC_SHIFT;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);
  localparam logic signed [CORDIC_W-1:0] CORDIC_HALF = CORDIC_W'(1) <<< (CORDIC_SHIFT - 1);

  localparam logic [TURN_BITS-1:0] QUARTER_TURN = TURN_BITS'(1) << (TURN_BITS - 2);
  localparam logic [TURN_BITS-1:0] HALF_TURN    = TURN_BITS'(1) << (TURN_BITS - 1);
  localparam logic [TURN_BITS-1:0] ANGLE_MASK   = TURN_BITS'((64'd1 << ANGLE_BITS) - 64'd1);

  // atan(2^-i) in 2^32-per-turn units.
  localparam logic [TURN_BITS-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41
  };

  // Products and sums of Q1.FRAC_BITS values.
  localparam int PROD_W = 2 * OUT_BITS;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] ONE_POS    = SUM_W'(1) <<< FRAC_BITS;
  localparam logic signed [SUM_W-1:0] ONE_NEG    = -ONE_POS;

  // Pipeline depth: prep, CORDIC steps, round, sign/clamp; then four matrix stages.
  localparam int SC_LATENCY = CORDIC_STEPS + 3;
  localparam int PIPE_DEPTH = SC_LATENCY + 4;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] x_angle;
    logic signed [FIELD_BITS-1:0] y_angle;
    logic signed [FIELD_BITS-1:0] z_angle;
  } angles_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] m00;
    logic signed [OUT_BITS-1:0] m01;
    logic signed [OUT_BITS-1:0] m02;
    logic signed [OUT_BITS-1:0] m10;
    logic signed [OUT_BITS-1:0] m11;
    logic signed [OUT_BITS-1:0] m12;
    logic signed [OUT_BITS-1:0] m20;
    logic signed [OUT_BITS-1:0] m21;
    logic signed [OUT_BITS-1:0] m22;
  } matrix_t;

  // Round to nearest at FRAC_BITS, halves toward plus infinity.
  function automatic logic signed [SUM_W-1:0] round_frac(input logic signed [SUM_W-1:0] v);
    return (v + ROUND_HALF) >>> FRAC_BITS;
  endfunction

  // Clamp to [-1.0, 1.0] in Q1.FRAC_BITS.
  function automatic logic signed [OUT_BITS-1:0] sat_one(input logic signed [SUM_W-1:0] v);
    if (v > ONE_POS) return OUT_BITS'(ONE_POS);
    if (v < ONE_NEG) return OUT_BITS'(ONE_NEG);
    return OUT_BITS'(v);
  endfunction

  function automatic logic signed [PROD_W-1:0] mul_q(input logic signed [OUT_BITS-1:0] a,
                                                     input logic signed [OUT_BITS-1:0] b);
    return PROD_W'(a) * PROD_W'(b);
  endfunction

endpackage

// ----- hdl/ezr_sincos.sv -----
// Pipelined CORDIC that gives the sine and cosine of one binary angle per cycle while en is high.
`timescale 1ns / 1ps

module ezr_sincos import ezr_pkg::*; (
  input  logic                       clk,
  input  logic                       en,
  input  logic [FIELD_BITS-1:0]      angle,
  output logic signed [OUT_BITS-1:0] sine,
  output logic signed [OUT_BITS-1:0] cosine
);

  logic [TURN_BITS-1:0]        turn;
  logic [TURN_BITS-1:0]        quad;
  logic [TURN_BITS-1:0]        folded;
  logic                        fold;

  logic signed [CORDIC_W-1:0]  xs [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0]  ys [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0]  zs [CORDIC_STEPS+1];
  logic                        neg [CORDIC_STEPS+1];

  logic signed [CORDIC_RND_W-1:0] x_rnd;
  logic signed [CORDIC_RND_W-1:0] y_rnd;
  logic                           neg_rnd;

  // Angles in the left half-plane are turned by half a turn; results are negated at the end.
  always_comb begin
    turn   = ({{(TURN_BITS-FIELD_BITS){1'b0}}, angle} & ANGLE_MASK) << (TURN_BITS - ANGLE_BITS);
    quad   = turn + QUARTER_TURN;
    fold   = quad[TURN_BITS-1];
    folded = fold ? turn + HALF_TURN : turn;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]  <= CORDIC_GAIN;
      ys[0]  <= '0;
      zs[0]  <= {{(CORDIC_W-TURN_BITS){folded[TURN_BITS-1]}}, folded};
      neg[0] <= fold;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CORDIC_W-1:0] atan_ext;
    assign atan_ext = {{(CORDIC_W-TURN_BITS){1'b0}}, ATAN_TURN[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][CORDIC_W-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_ext;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_ext;
        end
        neg[i+1] <= neg[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_rnd   <= CORDIC_RND_W'((xs[CORDIC_STEPS] + CORDIC_HALF) >>> CORDIC_SHIFT);
      y_rnd   <= CORDIC_RND_W'((ys[CORDIC_STEPS] + CORDIC_HALF) >>> CORDIC_SHIFT);
      neg_rnd <= neg[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cosine <= sat_one(SUM_W'(neg_rnd ? -x_rnd : x_rnd));
      sine   <= sat_one(SUM_W'(neg_rnd ? -y_rnd : y_rnd));
    end
  end

endmodule

// ----- hdl/euler_zxy_to_rotation_matrix_top.sv -----
// Top level of the ZXY Euler angle to rotation matrix block.
`timescale 1ns / 1ps

// Usage:
// An angle triple (x_angle, y_angle, z_angle) arrives on the angles channel as
// binary angles, 2^ANGLE_BITS per full turn. A transfer happens at a rising
// edge where angles_valid and angles_ready are both high. The nine matrix
// entries leave on the matrix channel as Q1.FRAC_BITS values clamped to
// plus or minus 1.0, one result per accepted triple, in order.
// The path holds 33 register stages, from the input registers to the output
// register. It takes one triple per cycle when nothing stalls. The depth is
// set by a prep stage and the 25-step CORDIC, one step per stage, followed
// by rounding, sign/clamp, product, sum and saturation stages.
// When the receiver holds matrix_ready low, the finished result waits in the
// output register. The pipeline keeps moving, and keeps taking transfers, as
// long as its last stage is empty; it freezes as a whole only when a second
// finished result would need the output register. Nothing is lost or repeated.
// Reset (rst, synchronous, active high) clears every valid bit; data registers
// are not reset, and the block is ready as soon as reset is released.

module euler_zxy_to_rotation_matrix_top import ezr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    angles_valid,
  output logic    angles_ready,
  input  angles_t angles,
  output logic    matrix_valid,
  input  logic    matrix_ready,
  output matrix_t matrix
);

  // One valid bit per pipeline stage, moving with the data.
  logic [PIPE_DEPTH-1:0] v;
  logic                  en;

  logic signed [OUT_BITS-1:0] sx, cx, sy, cy, sz, cz;

  // Stage P1: all two-factor products.
  logic signed [PROD_W-1:0]   sxsy_1, sxcy_1;
  logic signed [PROD_W-1:0]   czcy_1, szcx_1, czsy_1, szcy_1, czcx_1, szsy_1, cxsy_1, cxcy_1;
  logic signed [OUT_BITS-1:0] sz_1, cz_1, nsx_1;

  // Stage P2: rounded sx*sy and sx*cy.
  logic signed [OUT_BITS-1:0] sxsy_2, sxcy_2;
  logic signed [PROD_W-1:0]   czcy_2, szcx_2, czsy_2, szcy_2, czcx_2, szsy_2, cxsy_2, cxcy_2;
  logic signed [OUT_BITS-1:0] sz_2, cz_2, nsx_2;

  // Stage P3: three-factor products.
  logic signed [PROD_W-1:0]   szsxsy_3, czsxsy_3, szsxcy_3, czsxcy_3;
  logic signed [PROD_W-1:0]   czcy_3, szcx_3, czsy_3, szcy_3, czcx_3, szsy_3, cxsy_3, cxcy_3;
  logic signed [OUT_BITS-1:0] nsx_3;

  // Stage P4: exact entry sums.
  logic signed [SUM_W-1:0]    s00, s01, s02, s10, s11, s12, s20, s22;
  logic signed [OUT_BITS-1:0] nsx_4;

  // The whole pipeline holds only when its last stage has a result and the
  // output register is still full and not being taken.
  assign en           = !(matrix_valid && !matrix_ready && v[PIPE_DEPTH-1]);
  assign angles_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[PIPE_DEPTH-2:0], angles_valid};
    end
  end

  ezr_sincos u_sc_x (
    .clk    (clk),
    .en     (en),
    .angle  (angles.x_angle),
    .sine   (sx),
    .cosine (cx)
  );

  ezr_sincos u_sc_y (
    .clk    (clk),
    .en     (en),
    .angle  (angles.y_angle),
    .sine   (sy),
    .cosine (cy)
  );

  ezr_sincos u_sc_z (
    .clk    (clk),
    .en     (en),
    .angle  (angles.z_angle),
    .sine   (sz),
    .cosine (cz)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sxsy_1 <= mul_q(sx, sy);
      sxcy_1 <= mul_q(sx, cy);
      czcy_1 <= mul_q(cz, cy);
      szcx_1 <= mul_q(sz, cx);
      czsy_1 <= mul_q(cz, sy);
      szcy_1 <= mul_q(sz, cy);
      czcx_1 <= mul_q(cz, cx);
      szsy_1 <= mul_q(sz, sy);
      cxsy_1 <= mul_q(cx, sy);
      cxcy_1 <= mul_q(cx, cy);
      sz_1   <= sz;
      cz_1   <= cz;
      nsx_1  <= -sx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sxsy_2 <= OUT_BITS'(round_frac(SUM_W'(sxsy_1)));
      sxcy_2 <= OUT_BITS'(round_frac(SUM_W'(sxcy_1)));
      czcy_2 <= czcy_1;
      szcx_2 <= szcx_1;
      czsy_2 <= czsy_1;
      szcy_2 <= szcy_1;
      czcx_2 <= czcx_1;
      szsy_2 <= szsy_1;
      cxsy_2 <= cxsy_1;
      cxcy_2 <= cxcy_1;
      sz_2   <= sz_1;
      cz_2   <= cz_1;
      nsx_2  <= nsx_1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      szsxsy_3 <= mul_q(sz_2, sxsy_2);
      czsxsy_3 <= mul_q(cz_2, sxsy_2);
      szsxcy_3 <= mul_q(sz_2, sxcy_2);
      czsxcy_3 <= mul_q(cz_2, sxcy_2);
      czcy_3   <= czcy_2;
      szcx_3   <= szcx_2;
      czsy_3   <= czsy_2;
      szcy_3   <= szcy_2;
      czcx_3   <= czcx_2;
      szsy_3   <= szsy_2;
      cxsy_3   <= cxsy_2;
      cxcy_3   <= cxcy_2;
      nsx_3    <= nsx_2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s00   <= SUM_W'(czcy_3) + SUM_W'(szsxsy_3);
      s01   <= SUM_W'(szcx_3);
      s02   <= SUM_W'(szsxcy_3) - SUM_W'(czsy_3);
      s10   <= SUM_W'(czsxsy_3) - SUM_W'(szcy_3);
      s11   <= SUM_W'(czcx_3);
      s12   <= SUM_W'(szsy_3) + SUM_W'(czsxcy_3);
      s20   <= SUM_W'(cxsy_3);
      s22   <= SUM_W'(cxcy_3);
      nsx_4 <= nsx_3;
    end
  end

  // Output register: every entry but m21, which takes -sx as it is, is rounded once and clamped on the way in.
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_valid <= 1'b0;
    end else if (en && v[PIPE_DEPTH-1]) begin
      matrix_valid <= 1'b1;
    end else if (matrix_ready) begin
      matrix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v[PIPE_DEPTH-1]) begin
      matrix.m00 <= sat_one(round_frac(s00));
      matrix.m01 <= sat_one(round_frac(s01));
      matrix.m02 <= sat_one(round_frac(s02));
      matrix.m10 <= sat_one(round_frac(s10));
      matrix.m11 <= sat_one(round_frac(s11));
      matrix.m12 <= sat_one(round_frac(s12));
      matrix.m20 <= sat_one(round_frac(s20));
      matrix.m21 <= nsx_4;
      matrix.m22 <= sat_one(round_frac(s22));
    end
  end

endmodule

// ----- bench/tb_euler_zxy_to_rotation_matrix_top.sv -----
// Self-checking testbench for the ZXY Euler angle to rotation matrix block.
`timescale 1ns / 1ps

// Angle triples go in on the angles channel and each one is scored against a
// bit-exact fixed-point prediction of its nine matrix entries. A short run of
// corner triples comes first: zero, the ends of the field, and angles at and
// around the quarter turns, where the sine/cosine quadrant fold switches over
// and the entries saturate at plus or minus one. Random triples follow in four
// flow-control phases: free flow, a mostly idle sender, a mostly stalled
// receiver, and both idling part of the time. During free flow the receiver
// also holds off for a long stretch so that the pipeline fills and
// backpressures the sender. Between phases the sender waits for every
// expected matrix to come back.
module tb_euler_zxy_to_rotation_matrix_top;
  import ezr_pkg::angles_t;
  import ezr_pkg::matrix_t;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 11;
  localparam int QUIET_LIMIT   = 3000;
  localparam int TAIL_CYCLES   = 40;
  localparam int HOLD_CYCLES   = 200;
  localparam int PHASE_ITEMS   = 280;
  localparam int PRESSURE_ITEMS = 60;

  // Number formats of the angle and matrix fields.
  localparam int ANG_W       = 16;
  localparam int FRAC        = 14;
  localparam int ENTRY_W     = FRAC + 2;
  localparam int STEPS       = 25;
  localparam int VEC_FRAC    = 30;
  localparam longint VEC_GAIN = 652032874;
  localparam longint UNIT    = longint'(1) << FRAC;

  // atan(2^-i), with a full turn being 2^32.
  localparam longint ARC_TURN32 [STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41
  };

  typedef struct {
    angles_t angles;
    matrix_t matrix;
  } predicted_t;

  // Keeps the matrices still owed by the block, in transfer order, and scores
  // every matrix the block hands out against the oldest of them.
  class rotation_scoreboard;
    predicted_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    // Add half an LSB, then shift right arithmetically.
    function longint round_q(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function longint clamp_unit(longint v);
      if (v > UNIT) return UNIT;
      if (v < -UNIT) return -UNIT;
      return v;
    endfunction

    // Sine and cosine of a binary angle through a rotation-mode CORDIC. Angles
    // in the left half plane are folded by half a turn and the results negated.
    function void sin_cos(input logic [ANG_W-1:0] angle, output longint s, output longint c);
      logic [31:0] t;
      logic [31:0] probe;
      bit          neg;
      longint      x, y, z, nx;
      t = {angle, {(32 - ANG_W){1'b0}}};
      probe = t + 32'h4000_0000;
      neg = probe[31];
      if (neg) t = t + 32'h8000_0000;
      z = longint'($signed(t));
      x = VEC_GAIN;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - ARC_TURN32[i];
        end else begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + ARC_TURN32[i];
        end
        x = nx;
      end
      x = round_q(x, VEC_FRAC - FRAC);
      y = round_q(y, VEC_FRAC - FRAC);
      if (neg) begin
        x = -x;
        y = -y;
      end
      c = clamp_unit(x);
      s = clamp_unit(y);
    endfunction

    // Round an exact Q2.28 sum once and saturate it to one entry.
    function logic [ENTRY_W-1:0] to_entry(longint wide);
      return ENTRY_W'(clamp_unit(round_q(wide, FRAC)));
    endfunction

    function matrix_t predict_matrix(angles_t a);
      longint  sx, cx, sy, cy, sz, cz, sxsy, sxcy;
      matrix_t m;
      sin_cos(a.x_angle, sx, cx);
      sin_cos(a.y_angle, sy, cy);
      sin_cos(a.z_angle, sz, cz);
      sxsy = round_q(sx * sy, FRAC);
      sxcy = round_q(sx * cy, FRAC);
      m.m00 = to_entry(cz * cy + sz * sxsy);
      m.m01 = to_entry(sz * cx);
      m.m02 = to_entry(-(cz * sy) + sz * sxcy);
      m.m10 = to_entry(-(sz * cy) + cz * sxsy);
      m.m11 = to_entry(cz * cx);
      m.m12 = to_entry(sz * sy + cz * sxcy);
      m.m20 = to_entry(cx * sy);
      m.m21 = ENTRY_W'(-sx);
      m.m22 = to_entry(cx * cy);
      return m;
    endfunction

    function void note_input(angles_t a);
      predicted_t p;
      p.angles = a;
      p.matrix = predict_matrix(a);
      pending.push_back(p);
    endfunction

    // Entries are compared one by one; m00 sits in the top bits of the struct.
    function void check_result(matrix_t got);
      predicted_t           p;
      logic [ENTRY_W*9-1:0] want_bits, got_bits;
      logic [ENTRY_W-1:0]   want_e, got_e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected matrix transfer %h with nothing outstanding", got));
        return;
      end
      p = pending.pop_front();
      want_bits = p.matrix;
      got_bits  = got;
      for (int k = 0; k < 9; k++) begin
        want_e = want_bits[(8 - k) * ENTRY_W +: ENTRY_W];
        got_e  = got_bits[(8 - k) * ENTRY_W +: ENTRY_W];
        if (got_e !== want_e)
          report($sformatf("mismatch m%0d%0d for angles x=%0d y=%0d z=%0d: expected %0d got %0d",
                           k / 3, k % 3, p.angles.x_angle, p.angles.y_angle,
                           p.angles.z_angle, $signed(want_e), $signed(got_e)));
      end
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    angles_valid;
  logic    angles_ready;
  angles_t angles;
  logic    matrix_valid;
  logic    matrix_ready;
  matrix_t matrix;

  rotation_scoreboard sb;

  // Flow-control knobs, read by the driver and the receiver process.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  euler_zxy_to_rotation_matrix_top u_top (
    .clk          (clk),
    .rst          (rst),
    .angles_valid (angles_valid),
    .angles_ready (angles_ready),
    .angles       (angles),
    .matrix_valid (matrix_valid),
    .matrix_ready (matrix_ready),
    .matrix       (matrix)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Receiver side. A requested hold-off is counted down here, one cycle per
  // falling edge; otherwise ready is drawn at the current stall rate.
  initial begin
    matrix_ready = 1'b0;
    forever @(negedge clk) begin
      if (hold_left > 0) begin
        matrix_ready <= 1'b0;
        hold_left--;
      end else begin
        matrix_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Both channels are observed in one process so that a triple is always
  // recorded before anything that could follow it is scored.
  always @(posedge clk) begin
    if (!rst) begin
      if (angles_valid && angles_ready) sb.note_input(angles);
      if (matrix_valid && matrix_ready) sb.check_result(matrix);
    end
  end

  // Watchdog: the run is stuck if neither channel completes a transfer for
  // too long. The longest legal quiet spell is the deliberate hold-off.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever @(posedge clk) begin
      if (rst || (angles_valid && angles_ready) || (matrix_valid && matrix_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offers one triple and returns at the rising edge where it is taken. Valid
  // stays high on return; the next call or a drain decides whether it drops.
  task automatic send_triple(angles_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      angles_valid <= 1'b0;
    end
    @(negedge clk);
    angles_valid <= 1'b1;
    angles       <= a;
    @(posedge clk);
    while (!angles_ready) @(posedge clk);
  endtask

  // Sender goes quiet until every outstanding matrix has come back.
  task automatic drain_results();
    @(negedge clk);
    angles_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Half of the angles are fully random; the rest crowd the eighth-turn
  // points and the field ends, where folding and saturation happen.
  function automatic logic [ANG_W-1:0] random_angle();
    case ($urandom_range(3))
      0, 1: return ANG_W'($urandom);
      2: return ANG_W'($urandom_range(7) * 8192 + $urandom_range(4) - 2);
      default: return ($urandom_range(1) ? 16'h7fff : 16'h8000) ^ (16'h1 << $urandom_range(15));
    endcase
  endfunction

  task automatic send_random(int count);
    angles_t a;
    for (int n = 0; n < count; n++) begin
      a.x_angle = random_angle();
      a.y_angle = random_angle();
      a.z_angle = random_angle();
      send_triple(a);
    end
  endtask

  // Corner triples: zero, field ends, exact quarter turns on both sides of the
  // fold, one LSB around them, eighth turns and a few bit patterns.
  task automatic run_directed();
    int      corner [20][3];
    angles_t a;
    corner = '{
      '{0, 0, 0},               '{16384, 0, 0},           '{-16384, 0, 0},
      '{-32768, 0, 0},          '{0, 16384, 0},           '{0, 0, 16384},
      '{0, -16384, -32768},     '{32767, 32767, 32767},   '{-32768, -32768, -32768},
      '{16384, 16384, 16384},   '{-16384, -16384, -16384}, '{16383, 16385, -16385},
      '{-16383, 32767, -32767}, '{8192, 8192, 8192},      '{-8192, 8192, -8192},
      '{1, -1, 1},              '{-1, -1, -1},            '{21845, -21845, 10923},
      '{'h5555, 'h2aaa, -'h5556}, '{24576, -24576, 4096}
    };
    for (int i = 0; i < 20; i++) begin
      a.x_angle = ANG_W'(corner[i][0]);
      a.y_angle = ANG_W'(corner[i][1]);
      a.z_angle = ANG_W'(corner[i][2]);
      send_triple(a);
    end
  endtask

  initial begin
    rst          = 1'b1;
    angles_valid = 1'b0;
    angles       = '0;
    sb           = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      send_random(PHASE_ITEMS);
      if (phase == 0) begin
        // Receiver holds off while the sender keeps offering, so the pipeline
        // fills and angles_ready must drop until the hold-off ends.
        hold_left = HOLD_CYCLES;
        send_random(PRESSURE_ITEMS);
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/ezr_pkg.sv
hdl/ezr_sincos.sv
hdl/euler_zxy_to_rotation_matrix_top.sv
bench/tb_euler_zxy_to_rotation_matrix_top.sv
